// ===== hdl/ucrr_pkg.sv =====
// ---------------------------------------------------------------------------
// ucrr_pkg - shared types and tables for the USB control request responder
// Event and reply codes, request words, descriptor tables and stream layout.
// ---------------------------------------------------------------------------
package ucrr_pkg;

  // Default largest bulk packet in bytes
  localparam int MAX_PACKET_DEF = 64;

  // Stream widths
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 24;
  localparam int FUNC_W    = 3;
  localparam int KIND_W    = 3;
  localparam int SIZE_W    = 12;
  localparam int RLEN_W    = 7;
  localparam int POS_W     = 5;
  localparam int CLIP_W    = 6;

  // Descriptor lengths
  localparam logic [CLIP_W-1:0] DEV_DESC_LEN = 6'd18;
  localparam logic [CLIP_W-1:0] CFG_DESC_LEN = 6'd32;

  // Standard request words (bRequest << 8 | bmRequestType)
  localparam logic [15:0] REQ_GET_DESCRIPTOR = 16'h0680;
  localparam logic [15:0] REQ_SET_DEV_ADDR   = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG     = 16'h0900;
  localparam logic [15:0] REQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] REQ_GET_STATUS     = 16'h0080;
  localparam logic [15:0] REQ_GET_INTERFACE  = 16'h0a81;
  localparam logic [15:0] REQ_SET_INTERFACE  = 16'h0b01;

  // Descriptor selectors in wValue
  localparam logic [15:0] DESC_DEVICE = 16'h0100;
  localparam logic [15:0] DESC_CONFIG = 16'h0200;

  // Highest address + 1 for the device address request
  localparam logic [15:0] ADDR_LIMIT = 16'd128;

  // Event kinds on the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SETUP   = 3'd0,
    FUNC_RESET   = 3'd1,
    FUNC_IN_DONE = 3'd2,
    FUNC_WRITE   = 3'd3,
    FUNC_READ    = 3'd4
  } func_t;

  // Reply kinds on the output tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA   = 3'd0,
    KIND_EMPTY  = 3'd1,
    KIND_ACK    = 3'd2,
    KIND_STALL  = 3'd3,
    KIND_DONE   = 3'd4,
    KIND_ACCEPT = 3'd5,
    KIND_REFUSE = 3'd6,
    KIND_ERROR  = 3'd7
  } reply_kind_t;

  // Where data beats take their bytes from
  typedef enum logic [1:0] {
    SRC_DEV   = 2'd0,
    SRC_CFG   = 2'd1,
    SRC_REPLY = 2'd2
  } src_t;

  // One decoded answer, waiting to be sent as beats
  typedef struct packed {
    reply_kind_t       kind;
    src_t              src;
    logic [POS_W-1:0]  last_pos;
    logic              reply0;
    logic              cfg;
    logic [7:0]        gen;
    logic [RLEN_W-1:0] rlen;
  } job_t;

  // Device descriptor byte
  function automatic logic [7:0] dev_desc_byte(input logic [POS_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'd18;
      5'd1:    b = 8'd1;
      5'd3:    b = 8'd2;
      5'd7:    b = 8'd64;
      5'd8:    b = 8'd255;
      5'd9:    b = 8'd255;
      5'd10:   b = 8'd255;
      5'd11:   b = 8'd255;
      5'd13:   b = 8'd1;
      5'd17:   b = 8'd1;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // Configuration descriptor byte; endpoint sizes follow the packet limit
  function automatic logic [7:0] cfg_desc_byte(input logic [POS_W-1:0] idx,
                                               input logic [7:0] mp);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'd9;
      5'd1:    b = 8'd2;
      5'd2:    b = 8'd32;
      5'd4:    b = 8'd1;
      5'd5:    b = 8'd1;
      5'd7:    b = 8'h80;
      5'd8:    b = 8'd50;
      5'd9:    b = 8'd9;
      5'd10:   b = 8'd4;
      5'd13:   b = 8'd2;
      5'd14:   b = 8'hff;
      5'd18:   b = 8'd7;
      5'd19:   b = 8'd5;
      5'd20:   b = 8'h01;
      5'd21:   b = 8'd2;
      5'd22:   b = mp;
      5'd25:   b = 8'd7;
      5'd26:   b = 8'd5;
      5'd27:   b = 8'h82;
      5'd28:   b = 8'd2;
      5'd29:   b = mp;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/usb_control_request_responder.sv =====
// ---------------------------------------------------------------------------
// usb_control_request_responder - USB device standard request responder
// Decodes setup packets and bulk/bus events and streams out reply beats.
// ---------------------------------------------------------------------------
// Each accepted event is decoded in its accept cycle: device state updates at
// once and the answer is held in a job register that a beat sequencer hands
// to a registered output stage. Events answered by one beat stream back to
// back. A descriptor or reply answer of n
// bytes (n up to 32, clipped to wLength) holds the sequencer until its n beats are sent;
// the next event is taken in the cycle the last beat moves to the output
// register. Backpressure on the output side stalls the sequencer and, once
// the job register is full, the input side.
module usb_control_request_responder #(
  parameter int MAX_PACKET = ucrr_pkg::MAX_PACKET_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] req_word, [31:16] req_value, [47:32] req_index, [63:48] req_length,
  // [75:64] xfer_size, [76] out_ready, [79:77] zero
  input  logic [ucrr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [2:0] func
  input  logic [ucrr_pkg::FUNC_W-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] data_byte, [8] is_configured, [16:9] config_generation,
  // [23:17] read_length
  output logic [ucrr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [2:0] reply_kind
  output logic [ucrr_pkg::KIND_W-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam logic [ucrr_pkg::SIZE_W-1:0] MAX_PKT_SIZE = ucrr_pkg::SIZE_W'(MAX_PACKET);
  localparam logic [7:0]                  MAX_PKT_BYTE = 8'(MAX_PACKET);

  // Device state
  logic       configured_flag, configured_flag_next;
  logic       in_pending, in_pending_next;
  logic [7:0] generation_count, generation_count_next;

  // Job register and beat position
  logic                         job_valid;
  ucrr_pkg::job_t               job, job_next;
  logic [ucrr_pkg::POS_W-1:0]   job_pos;

  // Input fields
  logic [15:0]                  req_word, req_value, req_index, req_length;
  logic [ucrr_pkg::SIZE_W-1:0]  xfer_size;
  logic                         out_ready;
  logic                         accept;
  logic                         out_free, emit, job_done;

  assign req_word   = s_axis_tdata[15:0];
  assign req_value  = s_axis_tdata[31:16];
  assign req_index  = s_axis_tdata[47:32];
  assign req_length = s_axis_tdata[63:48];
  assign xfer_size  = s_axis_tdata[75:64];
  assign out_ready  = s_axis_tdata[76];

  // Handshake: take an event when the job register is empty or drains now
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = job_valid && out_free;
  assign job_done      = emit && (job_pos == job.last_pos);
  assign s_axis_tready = !job_valid || job_done;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode one event into a job and the next device state
  always_comb begin
    logic                           idx0, val0;
    logic [ucrr_pkg::CLIP_W-1:0]    dlen, clip;
    logic                           is_desc, now_cfg;
    ucrr_pkg::reply_kind_t          single;

    configured_flag_next  = configured_flag;
    in_pending_next       = in_pending;
    generation_count_next = generation_count;
    idx0    = (req_index == 16'd0);
    val0    = (req_value == 16'd0);
    dlen    = ucrr_pkg::DEV_DESC_LEN;
    clip    = '0;
    is_desc = 1'b0;
    now_cfg = (req_value == 16'd1);
    single  = ucrr_pkg::KIND_ERROR;

    job_next          = '0;
    job_next.src      = ucrr_pkg::SRC_REPLY;
    job_next.kind     = ucrr_pkg::KIND_ERROR;

    unique case (s_axis_tuser)
      ucrr_pkg::FUNC_SETUP: begin
        priority if (req_word == ucrr_pkg::REQ_GET_DESCRIPTOR && idx0 &&
                     req_value == ucrr_pkg::DESC_DEVICE) begin
          is_desc      = 1'b1;
          job_next.src = ucrr_pkg::SRC_DEV;
          dlen         = ucrr_pkg::DEV_DESC_LEN;
        end else if (req_word == ucrr_pkg::REQ_GET_DESCRIPTOR && idx0 &&
                     req_value == ucrr_pkg::DESC_CONFIG) begin
          is_desc      = 1'b1;
          job_next.src = ucrr_pkg::SRC_CFG;
          dlen         = ucrr_pkg::CFG_DESC_LEN;
        end else if (req_word == ucrr_pkg::REQ_SET_DEV_ADDR &&
                     req_value < ucrr_pkg::ADDR_LIMIT && idx0 &&
                     req_length == 16'd0) begin
          single = ucrr_pkg::KIND_ACK;
        end else if (req_word == ucrr_pkg::REQ_SET_CONFIG &&
                     req_value <= 16'd1 && idx0 && req_length == 16'd0) begin
          single = ucrr_pkg::KIND_ACK;
          configured_flag_next = now_cfg;
          if (now_cfg != configured_flag) begin
            in_pending_next = 1'b0;
            if (now_cfg) begin
              generation_count_next = generation_count + 8'd1;
            end
          end
        end else if (req_word == ucrr_pkg::REQ_GET_CONFIG && val0 && idx0 &&
                     req_length == 16'd1) begin
          is_desc         = 1'b1;
          dlen            = 6'd1;
          job_next.reply0 = configured_flag;
        end else if (req_word == ucrr_pkg::REQ_GET_STATUS && val0 && idx0 &&
                     req_length == 16'd2) begin
          is_desc = 1'b1;
          dlen    = 6'd2;
        end else if (req_word == ucrr_pkg::REQ_GET_INTERFACE && val0 && idx0 &&
                     req_length == 16'd1 && configured_flag) begin
          is_desc = 1'b1;
          dlen    = 6'd1;
        end else if (req_word == ucrr_pkg::REQ_SET_INTERFACE && val0 && idx0 &&
                     req_length == 16'd0 && configured_flag) begin
          single = ucrr_pkg::KIND_ACK;
        end else begin
          single = ucrr_pkg::KIND_STALL;
        end
      end
      ucrr_pkg::FUNC_RESET: begin
        configured_flag_next = 1'b0;
        in_pending_next      = 1'b0;
        single               = ucrr_pkg::KIND_DONE;
      end
      ucrr_pkg::FUNC_IN_DONE: begin
        in_pending_next = 1'b0;
        single          = ucrr_pkg::KIND_DONE;
      end
      ucrr_pkg::FUNC_WRITE: begin
        priority if (!configured_flag || in_pending) begin
          single = ucrr_pkg::KIND_REFUSE;
        end else if (xfer_size == '0 || xfer_size > MAX_PKT_SIZE) begin
          single = ucrr_pkg::KIND_ERROR;
        end else begin
          single          = ucrr_pkg::KIND_ACCEPT;
          in_pending_next = 1'b1;
        end
      end
      ucrr_pkg::FUNC_READ: begin
        priority if (!configured_flag || in_pending || !out_ready) begin
          single = ucrr_pkg::KIND_REFUSE;
        end else if (xfer_size > MAX_PKT_SIZE) begin
          single = ucrr_pkg::KIND_ERROR;
        end else begin
          single        = ucrr_pkg::KIND_ACCEPT;
          job_next.rlen = xfer_size[ucrr_pkg::RLEN_W-1:0];
        end
      end
      default: begin
        single = ucrr_pkg::KIND_ERROR;
      end
    endcase

    // Clip reply length to wLength
    clip = (req_length < 16'(dlen)) ? req_length[ucrr_pkg::CLIP_W-1:0] : dlen;

    priority if (is_desc && clip != '0) begin
      job_next.kind     = ucrr_pkg::KIND_DATA;
      job_next.last_pos = ucrr_pkg::POS_W'(clip - 6'd1);
    end else if (is_desc) begin
      job_next.kind     = ucrr_pkg::KIND_EMPTY;
      job_next.last_pos = '0;
    end else begin
      job_next.kind     = single;
      job_next.last_pos = '0;
    end

    job_next.cfg = configured_flag_next;
    job_next.gen = generation_count_next;
  end

  // Update device state on each accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      configured_flag  <= 1'b0;
      in_pending       <= 1'b0;
      generation_count <= 8'd0;
    end else if (accept) begin
      configured_flag  <= configured_flag_next;
      in_pending       <= in_pending_next;
      generation_count <= generation_count_next;
    end
  end

  // Load a job or advance through its beats
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_pos   <= '0;
    end else if (accept) begin
      job_valid <= 1'b1;
      job_pos   <= '0;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end else if (emit) begin
      job_pos <= job_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0] beat_byte;
    beat_byte = 8'd0;
    if (job.kind == ucrr_pkg::KIND_DATA) begin
      unique case (job.src)
        ucrr_pkg::SRC_DEV:   beat_byte = ucrr_pkg::dev_desc_byte(job_pos);
        ucrr_pkg::SRC_CFG:   beat_byte = ucrr_pkg::cfg_desc_byte(job_pos, MAX_PKT_BYTE);
        ucrr_pkg::SRC_REPLY: beat_byte = (job_pos == '0) ? {7'd0, job.reply0} : 8'd0;
        default:             beat_byte = 8'd0;
      endcase
    end
    if (emit) begin
      m_axis_tdata <= {job.rlen, job.gen, job.cfg, beat_byte};
      m_axis_tuser <= job.kind;
      m_axis_tlast <= (job_pos == job.last_pos);
    end
  end

endmodule

// ===== hdl/ucrr_checker.sv =====
// ---------------------------------------------------------------------------
// ucrr_checker - port-level checks for the USB control request responder
// Watches the output stream for reset, stall and reply-shape rules.
// ---------------------------------------------------------------------------
module ucrr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ucrr_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [ucrr_pkg::KIND_W-1:0]    m_axis_tuser,
  input logic                           m_axis_tlast
);

  // Reset empties the output stage
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled beat changed");

  // Every answer but a data byte is a single, final beat with no byte
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ucrr_pkg::KIND_DATA |->
      m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("non-data reply not a lone last beat");

  // Read length shows only on an accepted event
  a_rlen_accept: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ucrr_pkg::KIND_ACCEPT |->
      m_axis_tdata[23:17] == 7'd0)
    else $error("read length on a reply that is not accepted");

endmodule

bind usb_control_request_responder ucrr_checker u_ucrr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== test/usb_control_request_responder_tb.sv =====
// ---------------------------------------------------------------------------
// usb_control_request_responder_tb - self-checking bench for the responder
// Streams setup, bus and bulk events into the block and checks every reply
// beat against a cycle-free model of the device state, with random idling
// on both stream sides and one long output stall.
// ---------------------------------------------------------------------------
module usb_control_request_responder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucrr_pkg::*;

  localparam int MAX_PKT       = MAX_PACKET_DEF;
  localparam int RANDOM_EVENTS = 382;
  localparam int HOLD_AT_BEATS = 150;
  localparam int HOLD_CYCLES   = 500;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PRINT_LIMIT   = 60;

  // One device event as it travels on the input stream
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [15:0]       req;
    logic [15:0]       val;
    logic [15:0]       idx;
    logic [15:0]       len;
    logic [SIZE_W-1:0] size;
    logic              ready;
  } event_t;

  // One reply beat
  typedef struct {
    reply_kind_t       kind;
    logic [7:0]        data_b;
    logic              last;
    logic              cfg;
    logic [7:0]        gen;
    logic [RLEN_W-1:0] rlen;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [FUNC_W-1:0]    s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;

  // Descriptor images as the host should see them
  logic [7:0] dev_table [18] = '{8'd18, 8'd1, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd64,
                                 8'hff, 8'hff, 8'hff, 8'hff, 8'd0, 8'd1, 8'd0, 8'd0,
                                 8'd0, 8'd1};
  logic [7:0] cfg_table [32] = '{8'd9, 8'd2, 8'd32, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
                                 8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'd0, 8'd0, 8'd0,
                                 8'd7, 8'd5, 8'h01, 8'd2, 8'(MAX_PKT), 8'd0, 8'd0,
                                 8'd7, 8'd5, 8'h82, 8'd2, 8'(MAX_PKT), 8'd0, 8'd0};

  // Device state tracked by the bench
  logic       cfg_on = 1'b0;
  logic       in_busy = 1'b0;
  logic [7:0] gen_cnt = 8'd0;

  event_t event_q [$];
  reply_t reply_q [$];
  int     err_count = 0;
  int     idle_cycles = 0;

  usb_control_request_responder #(
    .MAX_PACKET(MAX_PKT)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic event_t mk_ev(input logic [FUNC_W-1:0] func, input logic [15:0] req,
                                   input logic [15:0] val, input logic [15:0] idx,
                                   input logic [15:0] len, input logic [SIZE_W-1:0] size,
                                   input logic ready);
    event_t ev;
    ev.func  = func;
    ev.req   = req;
    ev.val   = val;
    ev.idx   = idx;
    ev.len   = len;
    ev.size  = size;
    ev.ready = ready;
    return ev;
  endfunction

  // Short lengths mostly, full range sometimes
  function automatic logic [15:0] pick_len();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 40));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 7) == 0) return SIZE_W'($urandom);
    return SIZE_W'($urandom_range(0, MAX_PKT + 6));
  endfunction

  // Build a well-formed standard request, other fields left as noise
  function automatic event_t good_setup(input event_t ev);
    ev.func = FUNC_SETUP;
    ev.idx  = 16'd0;
    ev.val  = 16'd0;
    case ($urandom_range(0, 7))
      0: begin
        ev.req = REQ_GET_DESCRIPTOR;
        ev.val = DESC_DEVICE;
        ev.len = pick_len();
      end
      1: begin
        ev.req = REQ_GET_DESCRIPTOR;
        ev.val = DESC_CONFIG;
        ev.len = pick_len();
      end
      2: begin
        ev.req = REQ_GET_CONFIG;
        ev.len = 16'd1;
      end
      3: begin
        ev.req = REQ_GET_STATUS;
        ev.len = 16'd2;
      end
      4: begin
        ev.req = REQ_GET_INTERFACE;
        ev.len = 16'd1;
      end
      5: begin
        ev.req = REQ_SET_DEV_ADDR;
        ev.val = 16'($urandom_range(0, ADDR_LIMIT - 1));
        ev.len = 16'd0;
      end
      6: begin
        ev.req = REQ_SET_INTERFACE;
        ev.len = 16'd0;
      end
      default: begin
        ev.req = REQ_SET_CONFIG;
        ev.val = 16'($urandom_range(0, 2) != 0);
        ev.len = 16'd0;
      end
    endcase
    return ev;
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    int     r;
    int     b;
    ev = mk_ev(FUNC_SETUP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               SIZE_W'($urandom), 1'($urandom));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      ev = good_setup(ev);
    end else if (r < 46) begin
      // near miss: one bit off in a qualifying field
      ev = good_setup(ev);
      b  = $urandom_range(0, 15);
      case ($urandom_range(0, 3))
        0: ev.req[b] = ~ev.req[b];
        1: ev.val[b] = ~ev.val[b];
        2: ev.idx[b] = ~ev.idx[b];
        default: ev.len[b] = ~ev.len[b];
      endcase
    end else if (r < 50) begin
      ev.func = FUNC_SETUP;
    end else if (r < 54) begin
      ev.func = FUNC_RESET;
    end else if (r < 64) begin
      ev.func = FUNC_IN_DONE;
    end else if (r < 80) begin
      ev.func = FUNC_WRITE;
      ev.size = pick_size();
    end else if (r < 97) begin
      ev.func  = FUNC_READ;
      ev.size  = pick_size();
      ev.ready = ($urandom_range(0, 4) != 0);
    end else begin
      ev.func = FUNC_W'(FUNC_READ + $urandom_range(1, 3));
    end
    return ev;
  endfunction

  // Work out the reply beats of one event and advance the device state
  task automatic predict_reply(input event_t ev);
    reply_t      r;
    reply_t      beats [$];
    reply_kind_t kind_one;
    logic [6:0]  rlen_one;
    int          data_total;
    int          n;
    src_t        src;
    logic [7:0]  reply0;
    logic        now_on;
    kind_one   = KIND_STALL;
    rlen_one   = '0;
    data_total = -1;
    src        = SRC_REPLY;
    reply0     = 8'd0;
    case (ev.func)
      FUNC_SETUP: begin
        if (ev.req == REQ_GET_DESCRIPTOR && ev.idx == 0 && ev.val == DESC_DEVICE) begin
          data_total = 18;
          src        = SRC_DEV;
        end else if (ev.req == REQ_GET_DESCRIPTOR && ev.idx == 0 && ev.val == DESC_CONFIG) begin
          data_total = 32;
          src        = SRC_CFG;
        end else if (ev.req == REQ_SET_DEV_ADDR && ev.val < ADDR_LIMIT && ev.idx == 0 &&
                     ev.len == 0) begin
          kind_one = KIND_ACK;
        end else if (ev.req == REQ_SET_CONFIG && ev.val <= 1 && ev.idx == 0 &&
                     ev.len == 0) begin
          // entering the configured state starts a new generation
          now_on = ev.val[0];
          if (now_on != cfg_on) begin
            in_busy = 1'b0;
            if (now_on) gen_cnt = gen_cnt + 8'd1;
          end
          cfg_on   = now_on;
          kind_one = KIND_ACK;
        end else if (ev.req == REQ_GET_CONFIG && ev.val == 0 && ev.idx == 0 &&
                     ev.len == 1) begin
          data_total = 1;
          reply0     = {7'd0, cfg_on};
        end else if (ev.req == REQ_GET_STATUS && ev.val == 0 && ev.idx == 0 &&
                     ev.len == 2) begin
          data_total = 2;
        end else if (ev.req == REQ_GET_INTERFACE && ev.val == 0 && ev.idx == 0 &&
                     ev.len == 1 && cfg_on) begin
          data_total = 1;
        end else if (ev.req == REQ_SET_INTERFACE && ev.val == 0 && ev.idx == 0 &&
                     ev.len == 0 && cfg_on) begin
          kind_one = KIND_ACK;
        end
      end
      FUNC_RESET: begin
        cfg_on   = 1'b0;
        in_busy  = 1'b0;
        kind_one = KIND_DONE;
      end
      FUNC_IN_DONE: begin
        in_busy  = 1'b0;
        kind_one = KIND_DONE;
      end
      FUNC_WRITE: begin
        if (!cfg_on || in_busy) kind_one = KIND_REFUSE;
        else if (ev.size == 0 || ev.size > MAX_PKT) kind_one = KIND_ERROR;
        else begin
          in_busy  = 1'b1;
          kind_one = KIND_ACCEPT;
        end
      end
      FUNC_READ: begin
        if (!cfg_on || in_busy || !ev.ready) kind_one = KIND_REFUSE;
        else if (ev.size > MAX_PKT) kind_one = KIND_ERROR;
        else begin
          kind_one = KIND_ACCEPT;
          rlen_one = ev.size[6:0];
        end
      end
      default: kind_one = KIND_ERROR;
    endcase

    // Expand into beats, clipping data answers to the host's length
    r.data_b = 8'd0;
    r.rlen   = '0;
    if (data_total >= 0) begin
      n = (ev.len < data_total) ? int'(ev.len) : data_total;
      if (n == 0) begin
        r.kind = KIND_EMPTY;
        beats.push_back(r);
      end
      for (int i = 0; i < n; i++) begin
        r.kind = KIND_DATA;
        case (src)
          SRC_DEV: r.data_b = dev_table[i];
          SRC_CFG: r.data_b = cfg_table[i];
          default: r.data_b = (i == 0) ? reply0 : 8'd0;
        endcase
        beats.push_back(r);
      end
    end else begin
      r.kind = kind_one;
      r.rlen = rlen_one;
      beats.push_back(r);
    end

    // Stamp state after the event and the closing flag
    for (int i = 0; i < beats.size(); i++) begin
      r      = beats[i];
      r.last = (i == beats.size() - 1);
      r.cfg  = cfg_on;
      r.gen  = gen_cnt;
      reply_q.push_back(r);
    end
  endtask

  // Drive events from the pending queue, with gaps between them
  event_t cur_ev;
  int     src_wait = 0;
  int     src_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_reply(cur_ev);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
          cur_ev = event_q.pop_front();
          s_axis_tdata  <= {3'b000, cur_ev.ready, cur_ev.size, cur_ev.len, cur_ev.idx,
                            cur_ev.val, cur_ev.req};
          s_axis_tuser  <= cur_ev.func;
          s_axis_tvalid <= 1'b1;
          // pick the gap that follows this beat
          if (src_calm > 0) begin
            src_calm--;
            src_wait = 0;
          end else if ($urandom_range(0, 15) == 0) begin
            src_calm = $urandom_range(15, 40);
            src_wait = 0;
          end else begin
            src_wait = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Accept reply beats with random stalls and one long hold
  int  sink_stall = 0;
  int  sink_calm = 0;
  int  sink_hold = 0;
  int  sink_beats = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sink_beats++;
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && sink_beats >= HOLD_AT_BEATS) begin
        hold_done = 1'b1;
        sink_hold = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 31) == 0) sink_calm = $urandom_range(20, 60);
        else if ($urandom_range(0, 2) == 0) sink_stall = pick_gap();
      end
    end
  end

  // Compare each reply beat with the oldest expectation
  reply_t got;
  reply_t want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.data_b = m_axis_tdata[7:0];
      got.cfg    = m_axis_tdata[8];
      got.gen    = m_axis_tdata[16:9];
      got.rlen   = m_axis_tdata[23:17];
      got.kind   = reply_kind_t'(m_axis_tuser);
      got.last   = m_axis_tlast;
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d data %0d", got.kind, got.data_b));
      end else begin
        want = reply_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("reply_kind %0d, want %0d", got.kind, want.kind));
        if (got.data_b !== want.data_b)
          report_mismatch($sformatf("data_byte %0d, want %0d", got.data_b, want.data_b));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        if (got.cfg !== want.cfg)
          report_mismatch($sformatf("is_configured %0b, want %0b", got.cfg, want.cfg));
        if (got.gen !== want.gen)
          report_mismatch($sformatf("config_generation %0d, want %0d", got.gen, want.gen));
        if (got.rlen !== want.rlen)
          report_mismatch($sformatf("read_length %0d, want %0d", got.rlen, want.rlen));
      end
    end
  end

  // End the run if neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // descriptor fetches: empty, clipped by the table, clipped by the host, bad index
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'd0, 16'd0,
                            '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'd0, 16'hffff,
                            '1, 1'b1));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_DESCRIPTOR, DESC_CONFIG, 16'd0, 16'd9,
                            '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_DESCRIPTOR, DESC_CONFIG, 16'd0, 16'd33,
                            '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_DESCRIPTOR, DESC_DEVICE, 16'hffff, 16'd18,
                            '0, 1'b0));
    // address limits and requests that need the configured state
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_SET_DEV_ADDR, ADDR_LIMIT - 16'd1, 16'd0, 16'd0,
                            '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_SET_DEV_ADDR, ADDR_LIMIT, 16'd0, 16'd0, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_INTERFACE, 16'd0, 16'd0, 16'd1, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, 12'd8, 1'b0));
    // configure, repeat the same value, then requests in the configured state
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_SET_CONFIG, 16'd1, 16'd0, 16'd0, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_CONFIG, 16'd0, 16'd0, 16'd1, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_GET_INTERFACE, 16'd0, 16'd0, 16'd1, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_SET_INTERFACE, 16'd0, 16'd0, 16'd0, '0, 1'b0));
    // bulk write sizes, pending IN, bulk reads
    event_q.push_back(mk_ev(FUNC_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 1'b0));
    event_q.push_back(mk_ev(FUNC_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, '1, 1'b0));
    event_q.push_back(mk_ev(FUNC_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, 12'(MAX_PKT), 1'b0));
    event_q.push_back(mk_ev(FUNC_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, 12'd1, 1'b0));
    event_q.push_back(mk_ev(FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 12'd10, 1'b1));
    event_q.push_back(mk_ev(FUNC_IN_DONE, 16'd0, 16'd0, 16'd0, 16'd0, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 12'd10, 1'b0));
    event_q.push_back(mk_ev(FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 12'(MAX_PKT + 1), 1'b1));
    event_q.push_back(mk_ev(FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 12'(MAX_PKT), 1'b1));
    // bad configuration value, bus reset, spare event codes
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_SET_CONFIG, 16'd2, 16'd0, 16'd0, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_RESET, 16'd0, 16'd0, 16'd0, 16'd0, '0, 1'b0));
    event_q.push_back(mk_ev(FUNC_SETUP, REQ_SET_CONFIG, 16'd0, 16'd0, 16'd0, '0, 1'b0));
    for (int f = 1; f <= 3; f++)
      event_q.push_back(mk_ev(FUNC_W'(FUNC_READ + f), '1, '1, '1, '1, '1, 1'b1));
    for (int i = 0; i < RANDOM_EVENTS; i++) event_q.push_back(rand_event());

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every event to go in and every reply to come back
    while (event_q.size() != 0 || s_axis_tvalid || reply_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ucrr_pkg.sv
hdl/usb_control_request_responder.sv
hdl/ucrr_checker.sv
test/usb_control_request_responder_tb.sv
